### rtl/ctp_pkg.sv
// Shared types, codes and constants of the coordinate-to-column pattern block.
// Used by the request channel interface, the sequencer and the top level.
`timescale 1ns / 1ps
`default_nettype none

package ctp_pkg;

  localparam int DIM_W        = 10;
  localparam int KEY_W        = 2 * DIM_W;
  localparam int CCOUNT_W     = 11;
  localparam int QIDX_W       = 11;
  localparam int MAX_ENTRIES_DEF = 256;

  localparam logic [CCOUNT_W-1:0] COL_COUNT_RST = 11'd1024;

  typedef enum logic [1:0] {
    REQ_CLEAR  = 2'd0,
    REQ_APPEND = 2'd1,
    REQ_QUERY  = 2'd2,
    REQ_NONE   = 2'd3
  } ctp_req_t;

  typedef enum logic [1:0] {
    ERR_OK   = 2'd0,
    ERR_DUP  = 2'd1,
    ERR_FULL = 2'd2,
    ERR_COL  = 2'd3
  } ctp_err_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ASCAN,
    ST_SHIFT,
    ST_QKEY,
    ST_QSCAN,
    ST_RESP
  } ctp_state_t;

  typedef struct packed {
    logic [9:0] sorted_row;
    logic [7:0] entry_position;
    logic [8:0] column_start;
    logic [8:0] entry_count;
    logic [1:0] error_code;
  } ctp_res_t;

endpackage

`default_nettype wire

### rtl/ctp_if.sv
// Valid/ready channel interfaces for the request and result items.
// The request interface depends on ctp_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface ctp_in_if import ctp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        req_type;
  logic [DIM_W-1:0]  row_index;
  logic [DIM_W-1:0]  col_index;
  logic [QIDX_W-1:0] query_index;

  modport source (output valid, req_type, row_index, col_index, query_index, input ready);
  modport sink   (input valid, req_type, row_index, col_index, query_index, output ready);
endinterface

interface ctp_out_if ();
  logic       valid;
  logic       ready;
  logic [9:0] sorted_row;
  logic [7:0] entry_position;
  logic [8:0] column_start;
  logic [8:0] entry_count;
  logic [1:0] error_code;

  modport source (output valid, sorted_row, entry_position, column_start, entry_count,
                  error_code, input ready);
  modport sink   (input valid, sorted_row, entry_position, column_start, entry_count,
                  error_code, output ready);
endinterface

`default_nettype wire

### rtl/coo_to_csc_pattern.sv
// Top level of the coordinate-to-compressed-column pattern block.
// Depends on ctp_pkg, ctp_if, ctp_ram and ctp_engine.
//
// Usage: request items arrive on in_ch (valid/ready). req_type selects clear,
// append of a (row, column) entry, or a query for index query_index. Every item
// yields exactly one result item on out_ch carrying the sorted row, the sorted
// position of a loaded entry, the column start pointer, the entry count and
// the sticky error code. cfg_we/cfg_wdata write the column count; write it
// only while no item is in flight.
//
// Entries live in a table RAM of {column,row} words in load order. A second
// RAM holds the rows in column-then-row order; while no duplicate is present
// an insertion pass on each stored append keeps it sorted. One item is
// worked on at a time. Clear, type 3 and dropped entries go straight to the
// result. An append scans the table for a duplicate and for the insertion
// point, then, with no duplicate present, shifts the sorted rows up and
// places the new one; a query reads the named entry when query_index is
// below the entry count, then scans the table to rank it and to count the
// entries whose column lies below query_index. Every scan walks the one
// table read port.
// The result sits in an output register, so a stalled receiver holds only the
// last result; the engine waits with the next one until that register frees.
// Reset empties the table (no RAM clearing pass), clears the error, and sets
// the column count to 1024.
`timescale 1ns / 1ps
`default_nettype none

module coo_to_csc_pattern import ctp_pkg::*; #(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  ctp_in_if.sink                   in_ch,
  ctp_out_if.source                out_ch,
  input  wire logic                cfg_we,
  input  wire logic [CCOUNT_W-1:0] cfg_wdata
);

  localparam int AW = $clog2(MAX_ENTRIES);

  logic [CCOUNT_W-1:0] col_count_r;
  logic                out_valid_r;
  ctp_res_t            out_r;

  logic                eng_idle;
  logic                res_valid;
  logic                res_ready;
  ctp_res_t            res;
  logic                start;

  logic                tbl_we;
  logic [AW-1:0]       tbl_waddr;
  logic [KEY_W-1:0]    tbl_wdata;
  logic [AW-1:0]       tbl_raddr;
  logic [KEY_W-1:0]    tbl_rdata;
  logic                srt_we;
  logic [AW-1:0]       srt_waddr;
  logic [DIM_W-1:0]    srt_wdata;
  logic [AW-1:0]       srt_raddr;
  logic [DIM_W-1:0]    srt_rdata;

  assign in_ch.ready = eng_idle;
  assign start       = in_ch.valid && eng_idle;
  assign res_ready   = !out_valid_r || out_ch.ready;

  // Column count register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_count_r <= COL_COUNT_RST;
    end else if (cfg_we) begin
      col_count_r <= cfg_wdata;
    end
  end

  // Output register: takes a finished result whenever it is empty or drains.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_r <= res;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.sorted_row     = out_r.sorted_row;
  assign out_ch.entry_position = out_r.entry_position;
  assign out_ch.column_start   = out_r.column_start;
  assign out_ch.entry_count    = out_r.entry_count;
  assign out_ch.error_code     = out_r.error_code;

  ctp_engine #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .idle        (eng_idle),
    .req_type    (in_ch.req_type),
    .row_index   (in_ch.row_index),
    .col_index   (in_ch.col_index),
    .query_index (in_ch.query_index),
    .col_count   (col_count_r),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res),
    .tbl_we      (tbl_we),
    .tbl_waddr   (tbl_waddr),
    .tbl_wdata   (tbl_wdata),
    .tbl_raddr   (tbl_raddr),
    .tbl_rdata   (tbl_rdata),
    .srt_we      (srt_we),
    .srt_waddr   (srt_waddr),
    .srt_wdata   (srt_wdata),
    .srt_raddr   (srt_raddr),
    .srt_rdata   (srt_rdata)
  );

  // Entry table in load order, {column, row} per word.
  ctp_ram #(
    .WIDTH (KEY_W),
    .DEPTH (MAX_ENTRIES)
  ) u_tbl_ram (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  // Row indexes in column-then-row order.
  ctp_ram #(
    .WIDTH (DIM_W),
    .DEPTH (MAX_ENTRIES)
  ) u_srt_ram (
    .clk   (clk),
    .we    (srt_we),
    .waddr (srt_waddr),
    .wdata (srt_wdata),
    .raddr (srt_raddr),
    .rdata (srt_rdata)
  );

  // One item at a time: right after an accept the engine is busy.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input accepted while engine busy");

  // A result handed over by the engine always lands in the output register.
  assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res_ready) |=> out_valid_r)
    else $error("engine result lost");

  // With a duplicate present the pattern fields read as zero.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.error_code == ERR_DUP) |->
      (out_ch.sorted_row == '0 && out_ch.entry_position == '0 &&
       out_ch.column_start == '0))
    else $error("pattern fields nonzero under duplicate error");

  // The stored count never passes the table depth.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (32'(out_ch.entry_count) <= 32'(MAX_ENTRIES)))
    else $error("entry count beyond table depth");

endmodule

`default_nettype wire

### rtl/ctp_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module ctp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### rtl/ctp_engine.sv
// Sequencer and datapath: scans the entry table, keeps the row list in sorted
// order and forms one result per item. Depends on ctp_pkg; drives two ctp_ram ports.
`timescale 1ns / 1ps
`default_nettype none

module ctp_engine import ctp_pkg::*; #(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
  localparam int AW = $clog2(MAX_ENTRIES),
  localparam int CW = $clog2(MAX_ENTRIES + 1)
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     idle,
  input  wire logic [1:0]          req_type,
  input  wire logic [DIM_W-1:0]    row_index,
  input  wire logic [DIM_W-1:0]    col_index,
  input  wire logic [QIDX_W-1:0]   query_index,
  input  wire logic [CCOUNT_W-1:0] col_count,
  output logic                     res_valid,
  input  wire logic                res_ready,
  output ctp_res_t                 res,
  output logic                     tbl_we,
  output logic [AW-1:0]            tbl_waddr,
  output logic [KEY_W-1:0]         tbl_wdata,
  output logic [AW-1:0]            tbl_raddr,
  input  wire logic [KEY_W-1:0]    tbl_rdata,
  output logic                     srt_we,
  output logic [AW-1:0]            srt_waddr,
  output logic [DIM_W-1:0]         srt_wdata,
  output logic [AW-1:0]            srt_raddr,
  input  wire logic [DIM_W-1:0]    srt_rdata
);

  ctp_state_t        state_r, state_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [1:0]        err_r, err_nxt;
  logic              dup_r, dup_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;
  logic [QIDX_W-1:0] k_r, k_nxt;
  logic [CW-1:0]     ridx_r, ridx_nxt;
  logic              vld_r, vld_nxt;
  logic [CW-1:0]     rank_r, rank_nxt;
  logic [CW-1:0]     cst_r, cst_nxt;
  logic              hit_r, hit_nxt;
  logic [DIM_W-1:0]  srow_r, srow_nxt;
  logic              q_r, q_nxt;
  logic              kin_r, kin_nxt;
  logic              cok_r, cok_nxt;
  logic [CW-1:0]     p_r, p_nxt;
  logic              svld_r, svld_nxt;
  logic [AW-1:0]     wdst_r, wdst_nxt;

  logic              scan_issue;
  logic [CW-1:0]     pm1;

  assign scan_issue = ridx_r < count_r;
  assign pm1        = p_r - CW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      err_r   <= ERR_OK;
      dup_r   <= 1'b0;
      vld_r   <= 1'b0;
      svld_r  <= 1'b0;
      q_r     <= 1'b0;
      kin_r   <= 1'b0;
      cok_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      err_r   <= err_nxt;
      dup_r   <= dup_nxt;
      vld_r   <= vld_nxt;
      svld_r  <= svld_nxt;
      q_r     <= q_nxt;
      kin_r   <= kin_nxt;
      cok_r   <= cok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r  <= key_nxt;
    k_r    <= k_nxt;
    ridx_r <= ridx_nxt;
    rank_r <= rank_nxt;
    cst_r  <= cst_nxt;
    hit_r  <= hit_nxt;
    srow_r <= srow_nxt;
    p_r    <= p_nxt;
    wdst_r <= wdst_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    err_nxt   = err_r;
    dup_nxt   = dup_r;
    key_nxt   = key_r;
    k_nxt     = k_r;
    ridx_nxt  = ridx_r;
    vld_nxt   = 1'b0;
    rank_nxt  = rank_r;
    cst_nxt   = cst_r;
    hit_nxt   = hit_r;
    srow_nxt  = srow_r;
    q_nxt     = q_r;
    kin_nxt   = kin_r;
    cok_nxt   = cok_r;
    p_nxt     = p_r;
    svld_nxt  = 1'b0;
    wdst_nxt  = wdst_r;
    idle      = 1'b0;
    res_valid = 1'b0;
    tbl_we    = 1'b0;
    tbl_waddr = AW'(count_r);
    tbl_wdata = key_r;
    tbl_raddr = AW'(ridx_r);
    srt_we    = 1'b0;
    srt_waddr = wdst_r;
    srt_wdata = srt_rdata;
    srt_raddr = AW'(pm1);

    case (state_r)
      ST_IDLE: begin
        idle = 1'b1;
        if (start) begin
          q_nxt   = 1'b0;
          kin_nxt = 1'b0;
          cok_nxt = 1'b0;
          case (req_type)
            REQ_CLEAR: begin
              count_nxt = '0;
              err_nxt   = ERR_OK;
              dup_nxt   = 1'b0;
              state_nxt = ST_RESP;
            end
            REQ_APPEND: begin
              key_nxt = {col_index, row_index};
              if (CCOUNT_W'(col_index) >= col_count) begin
                if (err_r == ERR_OK) err_nxt = ERR_COL;
                state_nxt = ST_RESP;
              end else if (32'(count_r) >= 32'(MAX_ENTRIES)) begin
                if (err_r == ERR_OK) err_nxt = ERR_FULL;
                state_nxt = ST_RESP;
              end else begin
                ridx_nxt  = '0;
                rank_nxt  = '0;
                hit_nxt   = 1'b0;
                state_nxt = ST_ASCAN;
              end
            end
            REQ_QUERY: begin
              if (dup_r) begin
                state_nxt = ST_RESP;
              end else begin
                q_nxt     = 1'b1;
                k_nxt     = query_index;
                kin_nxt   = 32'(query_index) < 32'(count_r);
                cok_nxt   = query_index <= col_count;
                rank_nxt  = '0;
                cst_nxt   = '0;
                srow_nxt  = '0;
                ridx_nxt  = '0;
                tbl_raddr = AW'(query_index);
                srt_raddr = AW'(query_index);
                state_nxt = (32'(query_index) < 32'(count_r)) ? ST_QKEY : ST_QSCAN;
              end
            end
            default: begin
              state_nxt = ST_RESP;
            end
          endcase
        end
      end

      ST_ASCAN: begin
        if (scan_issue) begin
          ridx_nxt = ridx_r + CW'(1);
          vld_nxt  = 1'b1;
        end
        if (vld_r) begin
          if (tbl_rdata == key_r) begin
            hit_nxt = 1'b1;
          end else if (tbl_rdata < key_r) begin
            rank_nxt = rank_r + CW'(1);
          end
        end
        if (!scan_issue && !vld_r) begin
          tbl_we    = 1'b1;
          count_nxt = count_r + CW'(1);
          if (hit_r) begin
            dup_nxt = 1'b1;
            if (err_r == ERR_OK) err_nxt = ERR_DUP;
            state_nxt = ST_RESP;
          end else if (dup_r) begin
            state_nxt = ST_RESP;
          end else begin
            p_nxt     = count_r;
            state_nxt = ST_SHIFT;
          end
        end
      end

      ST_SHIFT: begin
        // Move rows at and above the insertion point up by one, top down.
        if (p_r > rank_r) begin
          p_nxt    = pm1;
          svld_nxt = 1'b1;
          wdst_nxt = AW'(p_r);
        end
        if (svld_r) begin
          srt_we = 1'b1;
        end else if (p_r == rank_r) begin
          srt_we    = 1'b1;
          srt_waddr = AW'(rank_r);
          srt_wdata = key_r[DIM_W-1:0];
          state_nxt = ST_RESP;
        end
      end

      ST_QKEY: begin
        key_nxt   = tbl_rdata;
        srow_nxt  = srt_rdata;
        state_nxt = ST_QSCAN;
      end

      ST_QSCAN: begin
        if (scan_issue) begin
          ridx_nxt = ridx_r + CW'(1);
          vld_nxt  = 1'b1;
        end
        if (vld_r) begin
          if (kin_r && (tbl_rdata < key_r)) begin
            rank_nxt = rank_r + CW'(1);
          end
          if (CCOUNT_W'(tbl_rdata[KEY_W-1:DIM_W]) < k_r) begin
            cst_nxt = cst_r + CW'(1);
          end
        end
        if (!scan_issue && !vld_r) begin
          state_nxt = ST_RESP;
        end
      end

      ST_RESP: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    res.sorted_row     = (q_r && kin_r) ? srow_r : '0;
    res.entry_position = (q_r && kin_r) ? 8'(rank_r) : '0;
    res.column_start   = (q_r && cok_r) ? 9'(cst_r) : '0;
    res.entry_count    = 9'(count_r);
    res.error_code     = err_r;
  end

endmodule

`default_nettype wire

### test/coo_to_csc_pattern_test.sv
// Self-checking testbench for the coordinate-to-compressed-column pattern block.
// Needs ctp_pkg, the ctp_in_if/ctp_out_if channel interfaces and the block's RTL.
// Every request is predicted here and each result item is compared field by field.
`timescale 1ns / 1ps

module coo_to_csc_pattern_test;
  import ctp_pkg::*;

  // Table depth of the block as built, and the widest index a query can carry.
  localparam int TABLE_DEPTH = MAX_ENTRIES_DEF;
  localparam int QIDX_MAX    = (1 << QIDX_W) - 1;
  // Cycles allowed after the last result for anything stray to show up.
  localparam int END_SETTLE  = 16;
  // Absolute limit of the run in ns (clock period 8 ns).
  localparam longint RUN_LIMIT_NS = 64'd40_000_000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // Driven copies of the block's inputs, all known from time zero.
  logic                req_valid = 1'b0;
  ctp_req_t            req_kind  = REQ_NONE;
  logic [DIM_W-1:0]    req_row   = '0;
  logic [DIM_W-1:0]    req_col   = '0;
  logic [QIDX_W-1:0]   req_qidx  = '0;
  logic                res_ready = 1'b0;
  logic                cfg_we    = 1'b0;
  logic [CCOUNT_W-1:0] cfg_wdata = '0;

  ctp_in_if  in_ch ();
  ctp_out_if out_ch ();

  assign in_ch.valid       = req_valid;
  assign in_ch.req_type    = req_kind;
  assign in_ch.row_index   = req_row;
  assign in_ch.col_index   = req_col;
  assign in_ch.query_index = req_qidx;
  assign out_ch.ready      = res_ready;

  coo_to_csc_pattern DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // The run is cut off here if the block ever stops answering.
  initial begin
    #(RUN_LIMIT_NS);
    $display("coo_to_csc_pattern_test: done, errors");
    $finish;
  end

  // Shadow of the block's state: the entries in load order, the entry count,
  // the sticky error, the duplicate flag and the column count register.
  logic [DIM_W-1:0]    tbl_row [TABLE_DEPTH];
  logic [DIM_W-1:0]    tbl_col [TABLE_DEPTH];
  int unsigned         tbl_count = 0;
  ctp_err_t            tbl_err = ERR_OK;
  bit                  tbl_dup = 1'b0;
  logic [CCOUNT_W-1:0] cols_in_use = COL_COUNT_RST;

  // Results that accepted requests still owe, oldest first.
  ctp_res_t pending_results[$];
  int       mismatch_count = 0;

  // When set, neither side inserts idle cycles.
  bit steady_flow = 1'b0;

  // Idle length for either side: mostly none, sometimes a few, now and then a long one.
  function automatic int gap_len();
    int pick;
    if (steady_flow) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Only the first error since the last clear is kept.
  function automatic void flag_error(ctp_err_t code);
    if (tbl_err == ERR_OK) tbl_err = code;
  endfunction

  // Applies one accepted request to the shadow state and returns the result
  // item the block must produce for it.
  function automatic ctp_res_t predict_item(ctp_req_t req, logic [DIM_W-1:0] row,
                                            logic [DIM_W-1:0] col, logic [QIDX_W-1:0] k);
    ctp_res_t          res;
    logic [KEY_W-1:0]  key_k;
    logic [KEY_W-1:0]  key_i;
    int unsigned       rank;
    int unsigned       lower_cols;
    res = '0;
    case (req)
      REQ_CLEAR: begin
        tbl_count = 0;
        tbl_err   = ERR_OK;
        tbl_dup   = 1'b0;
      end
      REQ_APPEND: begin
        // The column check takes precedence over the full-table check, and
        // both drop the entry. A duplicate is stored anyway.
        if (col >= cols_in_use) begin
          flag_error(ERR_COL);
        end else if (tbl_count >= TABLE_DEPTH) begin
          flag_error(ERR_FULL);
        end else begin
          for (int i = 0; i < tbl_count; i++) begin
            if (tbl_row[i] == row && tbl_col[i] == col) begin
              tbl_dup = 1'b1;
              flag_error(ERR_DUP);
              break;
            end
          end
          tbl_row[tbl_count] = row;
          tbl_col[tbl_count] = col;
          tbl_count++;
        end
      end
      REQ_QUERY: begin
        // Once a duplicate is stored, every query answers zeros until a clear.
        if (!tbl_dup) begin
          if (k < tbl_count) begin
            // Entries sort by column first, then row. Without duplicates
            // every key is distinct, so each rank is taken exactly once.
            key_k = {tbl_col[k], tbl_row[k]};
            rank  = 0;
            for (int j = 0; j < tbl_count; j++)
              if ({tbl_col[j], tbl_row[j]} < key_k) rank++;
            res.entry_position = rank[7:0];
            for (int i = 0; i < tbl_count; i++) begin
              key_i = {tbl_col[i], tbl_row[i]};
              rank  = 0;
              for (int j = 0; j < tbl_count; j++)
                if ({tbl_col[j], tbl_row[j]} < key_i) rank++;
              if (rank == k) begin
                res.sorted_row = tbl_row[i];
                break;
              end
            end
          end
          // The column start pointer is defined up to and including col_count.
          if (k <= cols_in_use) begin
            lower_cols = 0;
            for (int i = 0; i < tbl_count; i++)
              if (tbl_col[i] < k) lower_cols++;
            res.column_start = lower_cols[8:0];
          end
        end
      end
      default: ;
    endcase
    res.entry_count = tbl_count[8:0];
    res.error_code  = tbl_err;
    return res;
  endfunction

  // Offers one request item after a random idle stretch and waits for its
  // acceptance. Called right after a rising edge; returns right after the
  // edge at which the item was taken, with valid still high.
  task automatic send_item(input ctp_req_t req, input logic [DIM_W-1:0] row,
                           input logic [DIM_W-1:0] col, input logic [QIDX_W-1:0] k);
    int idle;
    idle = gap_len();
    if (idle > 0) begin
      req_valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    req_valid <= 1'b1;
    req_kind  <= req;
    req_row   <= row;
    req_col   <= col;
    req_qidx  <= k;
    do @(posedge clk); while (!in_ch.ready);
    pending_results.push_back(predict_item(req, row, col, k));
  endtask

  // Holds the sender off until every owed result has come back.
  task automatic drain_results();
    req_valid <= 1'b0;
    wait (pending_results.size() == 0);
    @(posedge clk);
  endtask

  // The column count is only written while the block has nothing in flight.
  task automatic write_col_count(input logic [CCOUNT_W-1:0] value);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    cols_in_use = value;
  endtask

  // Picks a query index: mostly within the loaded entries, often around the
  // column count, and sometimes anywhere the field allows.
  function automatic logic [QIDX_W-1:0] query_target();
    int pick;
    int hi;
    pick = $urandom_range(0, 99);
    if (pick < 60) return QIDX_W'($urandom_range(0, tbl_count));
    if (pick < 85) begin
      hi = (cols_in_use < QIDX_MAX) ? cols_in_use + 1 : QIDX_MAX;
      return QIDX_W'($urandom_range(0, hi));
    end
    return QIDX_W'($urandom_range(0, QIDX_MAX));
  endfunction

  // Result side: checks every accepted result item against the oldest
  // prediction and drives ready with random stalls.
  ctp_res_t want_res;
  int       hold_left = 0;

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (out_ch.valid && res_ready) begin
      if (pending_results.size() == 0) begin
        $error("result item arrived with no request waiting for it");
        mismatch_count++;
      end else begin
        want_res = pending_results.pop_front();
        check_field("sorted_row", 16'(want_res.sorted_row), 16'(out_ch.sorted_row));
        check_field("entry_position", 16'(want_res.entry_position),
                    16'(out_ch.entry_position));
        check_field("column_start", 16'(want_res.column_start), 16'(out_ch.column_start));
        check_field("entry_count", 16'(want_res.entry_count), 16'(out_ch.entry_count));
        check_field("error_code", 16'(want_res.error_code), 16'(out_ch.error_code));
      end
    end
    if (hold_left > 0) begin
      res_ready <= 1'b0;
      hold_left--;
    end else begin
      res_ready <= 1'b1;
      hold_left = gap_len();
    end
  end

  // Right after reset: queries on an empty table, an unused request type with
  // every field bit set, and a clear of a table that holds nothing.
  task automatic test_empty_table();
    send_item(REQ_QUERY, '0, '0, '0);
    send_item(REQ_QUERY, '0, '0, 11'd1024);
    send_item(REQ_NONE, '1, '1, '1);
    send_item(REQ_CLEAR, '1, '1, '1);
  endtask

  // A handful of entries at the corners of the coordinate range, two pairs sharing
  // a column so the row order inside a column matters, then queries on positions
  // 0, 2 and 4, past the last entry, on the column count and at the top of the index field.
  task automatic test_basic_pattern();
    send_item(REQ_APPEND, 10'd0, 10'd0, '0);
    send_item(REQ_APPEND, 10'd1023, 10'd1023, '0);
    send_item(REQ_APPEND, 10'd9, 10'd3, '0);
    send_item(REQ_APPEND, 10'd2, 10'd3, '0);
    send_item(REQ_APPEND, 10'd7, 10'd0, '1);
    send_item(REQ_QUERY, '1, '1, 11'd0);
    send_item(REQ_QUERY, '0, '0, 11'd2);
    send_item(REQ_QUERY, '0, '0, 11'd4);
    send_item(REQ_QUERY, '0, '0, 11'd5);
    send_item(REQ_QUERY, '0, '0, 11'd1023);
    send_item(REQ_QUERY, '0, '0, 11'd1024);
    send_item(REQ_QUERY, '0, '0, 11'd2047);
  endtask

  // Column count at zero rejects everything, at one accepts only column zero.
  // Then the count is lowered after loading, which must not disturb the
  // column start pointers up to the new count.
  task automatic test_column_limit();
    write_col_count('0);
    send_item(REQ_CLEAR, '0, '0, '0);
    send_item(REQ_APPEND, 10'd1, 10'd0, '0);
    send_item(REQ_CLEAR, '0, '0, '0);
    write_col_count(11'd1);
    send_item(REQ_APPEND, 10'd5, 10'd0, '0);
    send_item(REQ_APPEND, 10'd5, 10'd1, '0);
    send_item(REQ_QUERY, '0, '0, 11'd1);
    send_item(REQ_QUERY, '0, '0, 11'd2);
    write_col_count(COL_COUNT_RST);
    send_item(REQ_CLEAR, '0, '0, '0);
    send_item(REQ_APPEND, 10'd1, 10'd500, '0);
    send_item(REQ_APPEND, 10'd2, 10'd900, '0);
    write_col_count(11'd600);
    send_item(REQ_QUERY, '0, '0, 11'd600);
    send_item(REQ_QUERY, '0, '0, 11'd601);
  endtask

  // A repeated coordinate is stored and sets the sticky error; queries then
  // answer zeros, and a later column error does not replace the first one.
  task automatic test_duplicate();
    send_item(REQ_CLEAR, '0, '0, '0);
    send_item(REQ_APPEND, 10'd3, 10'd4, '0);
    send_item(REQ_APPEND, 10'd3, 10'd4, '0);
    send_item(REQ_QUERY, '0, '0, 11'd0);
    send_item(REQ_APPEND, 10'd8, 10'd700, '0);
    send_item(REQ_QUERY, '0, '0, 11'd5);
    send_item(REQ_CLEAR, '0, '0, '0);
    send_item(REQ_QUERY, '0, '0, 11'd5);
  endtask

  // Fills the whole table twice with distinct entries in scrambled column
  // order. The first pass overflows it and queries the full table; the second
  // shows the column check winning over the full check.
  task automatic test_full_table();
    logic [DIM_W-1:0] c;
    write_col_count(COL_COUNT_RST);
    for (int pass = 0; pass < 2; pass++) begin
      send_item(REQ_CLEAR, '0, '0, '0);
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        // 37 is odd, so i*37 walks every column group once.
        c = DIM_W'(((i * 37) % TABLE_DEPTH) * 4 + $urandom_range(0, 3));
        send_item(REQ_APPEND, DIM_W'($urandom), c, '0);
      end
      if (pass == 0) begin
        send_item(REQ_APPEND, 10'd1, 10'd10, '0);
        send_item(REQ_QUERY, '0, '0, 11'd0);
        send_item(REQ_QUERY, '0, '0, 11'd255);
        send_item(REQ_QUERY, '0, '0, 11'd256);
        send_item(REQ_QUERY, '0, '0, 11'd1024);
        repeat (4) send_item(REQ_QUERY, '0, '0, QIDX_W'($urandom_range(0, 1024)));
      end else begin
        write_col_count(11'd512);
        send_item(REQ_APPEND, 10'd1, 10'd900, '0);
        send_item(REQ_APPEND, 10'd1, 10'd10, '0);
        send_item(REQ_QUERY, '0, '0, 11'd512);
        write_col_count(COL_COUNT_RST);
        send_item(REQ_QUERY, '0, '0, 11'd1024);
      end
    end
  endtask

  // Random phases: an optional column count change, a clear, a batch of
  // mostly valid distinct entries with queries mixed in, and a closing burst
  // of queries. Duplicates, stray columns and unused request types are kept
  // rare so most phases reach the query logic with a clean table.
  task automatic test_random_sequences();
    int                sent;
    int                n_app;
    int                pick;
    int                c_lim;
    logic [DIM_W-1:0]  r;
    logic [DIM_W-1:0]  c;
    logic [KEY_W-1:0]  dup_key;
    bit                used [bit [KEY_W-1:0]];
    logic [KEY_W-1:0]  loaded[$];
    sent = 0;
    while (sent < 450) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        case ($urandom_range(0, 3))
          0: write_col_count(11'd1);
          1: write_col_count(COL_COUNT_RST);
          2: write_col_count(CCOUNT_W'($urandom_range(2, 16)));
          default: write_col_count(CCOUNT_W'($urandom_range(1, 1024)));
        endcase
      end else if (pick < 35) begin
        drain_results();
      end
      steady_flow = ($urandom_range(0, 5) == 0);

      send_item(REQ_CLEAR, DIM_W'($urandom), DIM_W'($urandom), QIDX_W'($urandom));
      sent++;
      used.delete();
      loaded.delete();

      pick = $urandom_range(0, 99);
      if (pick < 70) n_app = $urandom_range(1, 12);
      else if (pick < 97) n_app = $urandom_range(13, 60);
      else n_app = $urandom_range(240, 264);

      for (int i = 0; i < n_app; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 2 && loaded.size() > 0) begin
          dup_key = loaded[$urandom_range(0, loaded.size() - 1)];
          c = dup_key[KEY_W-1:DIM_W];
          r = dup_key[DIM_W-1:0];
        end else if (pick < 7 || cols_in_use == 0) begin
          // Any column at all, out of range whenever it reaches col_count.
          c = DIM_W'($urandom);
          r = DIM_W'($urandom);
        end else begin
          c_lim = (cols_in_use > 1024) ? 1024 : cols_in_use;
          repeat (8) begin
            if ($urandom_range(0, 1) == 0) c = DIM_W'($urandom_range(0, c_lim - 1));
            else c = DIM_W'($urandom_range(0, ((c_lim < 8) ? c_lim : 8) - 1));
            if ($urandom_range(0, 1) == 0) r = DIM_W'($urandom);
            else r = DIM_W'($urandom_range(0, 15));
            if (!used.exists({c, r})) break;
          end
        end
        send_item(REQ_APPEND, r, c, QIDX_W'($urandom));
        sent++;
        if (c < cols_in_use && !used.exists({c, r})) begin
          used[{c, r}] = 1'b1;
          loaded.push_back({c, r});
        end
        if ($urandom_range(0, 3) == 0) begin
          send_item(REQ_QUERY, DIM_W'($urandom), DIM_W'($urandom), query_target());
          sent++;
        end
        if ($urandom_range(0, 49) == 0)
          send_item(REQ_NONE, DIM_W'($urandom), DIM_W'($urandom), QIDX_W'($urandom));
      end

      // Now and then the column count moves under a loaded table.
      if ($urandom_range(0, 9) == 0) write_col_count(CCOUNT_W'($urandom_range(1, 1024)));
      repeat ($urandom_range(2, 10)) begin
        send_item(REQ_QUERY, DIM_W'($urandom), DIM_W'($urandom), query_target());
        sent++;
      end
    end
    steady_flow = 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_table();
    test_basic_pattern();
    test_column_limit();
    test_duplicate();
    test_full_table();
    test_random_sequences();

    // Let the last results come home, then give the block time to show
    // anything it should not send.
    drain_results();
    repeat (END_SETTLE) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d result items never arrived", pending_results.size());
      mismatch_count++;
    end
    if (mismatch_count == 0)
      $display("coo_to_csc_pattern_test: done, clean");
    else
      $display("coo_to_csc_pattern_test: done, errors");
    $finish;
  end

endmodule

### files.f
rtl/ctp_pkg.sv
rtl/ctp_if.sv
rtl/ctp_ram.sv
rtl/ctp_engine.sv
rtl/coo_to_csc_pattern.sv
test/coo_to_csc_pattern_test.sv
